/* rtl/assert_macros.svh */
// Assertion helpers for the checker module of this project.
// The clock and reset names are those of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define CSTL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lexer checker: assertion failed");

// The same, with a message of the caller's choosing.
`define CSTL_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

/* rtl/cstl_pkg.sv */
`timescale 1ns / 1ps

package cstl_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int MAX_RES       = 3;
	localparam int CNT_W         = $clog2(MAX_RES + 1);
	localparam int IDX_W         = $clog2(MAX_RES);
	// Result queue depth in beats of whole items; a power of two.
	localparam int FIFO_DEPTH    = 4;
	localparam int PTR_W         = $clog2(FIFO_DEPTH);
	localparam int FILL_W        = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [12:0] {
		MODE_IDLE    = 13'b0000000000001,
		MODE_SLASH   = 13'b0000000000010,
		MODE_LINE    = 13'b0000000000100,
		MODE_BLOCK   = 13'b0000000001000,
		MODE_STAR    = 13'b0000000010000,
		MODE_ZERO    = 13'b0000000100000,
		MODE_DEC     = 13'b0000001000000,
		MODE_OCT     = 13'b0000010000000,
		MODE_DEC_DOT = 13'b0000100000000,
		MODE_OCT_DOT = 13'b0001000000000,
		MODE_BIN     = 13'b0010000000000,
		MODE_HEX     = 13'b0100000000000,
		MODE_HALT    = 13'b1000000000000
	} mode_t;

	typedef enum logic [3:0] {
		K_TEXT   = 4'd0,
		K_EOF    = 4'd1,
		K_PLUS   = 4'd2,
		K_MINUS  = 4'd3,
		K_MUL    = 4'd4,
		K_DIV    = 4'd5,
		K_LPAREN = 4'd6,
		K_RPAREN = 4'd7,
		K_SEMI   = 4'd8,
		K_DOT    = 4'd9,
		K_DEC    = 4'd10,
		K_OCT    = 4'd11,
		K_HEX    = 4'd12,
		K_BIN    = 4'd13,
		K_ERR    = 4'd14
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE    = 3'd0,
		E_UNEXP   = 3'd1,
		E_OCT     = 3'd2,
		E_BIN     = 3'd3,
		E_HEX     = 3'd4,
		E_EOF_CMT = 3'd5
	} err_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_X     = 8'h78;

	// Up to three results caused by one character, in order.
	typedef struct packed {
		kind_t [MAX_RES-1:0]            kind;
		err_t  [MAX_RES-1:0]            code;
		logic  [MAX_RES-1:0][7:0]       text;
		logic  [CNT_W-1:0]              cnt;
	} bundle_t;

	function automatic bundle_t add(bundle_t b, kind_t k, err_t e, logic [7:0] t);
		if (b.cnt < CNT_W'(MAX_RES)) begin
			b.kind[b.cnt[IDX_W-1:0]] = k;
			b.code[b.cnt[IDX_W-1:0]] = e;
			b.text[b.cnt[IDX_W-1:0]] = t;
			b.cnt = b.cnt + CNT_W'(1);
		end
		return b;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
			((c >= 8'h41) && (c <= 8'h46));
	endfunction

endpackage

/* rtl/char_stream_token_lexer.sv */
`timescale 1ns / 1ps

// Character stream lexer: one source byte per input beat, tokens out.
// Input channel: char_valid / char_stall carry char_code and end_of_input.
// An end_of_input beat flushes any pending number and gives EOF, or an error.
// Output channel: result_valid / result_stall carry one result per beat;
// last_of_run marks the final result caused by one input beat.
// Each input beat is decoded in the cycle it is accepted; its results (one
// to three) are written as one entry into a four-entry result queue, and a
// beat with none is not queued. Through an empty queue, the first result of
// a beat is offered in the next cycle. One input beat is accepted per cycle
// while the queue has room; one result drains per cycle while result_stall
// is low, so beats with at most one result each run at one beat per cycle.
// When the receiver stalls, the queue fills and char_stall rises when it is
// full; a stalled result stays unchanged on the ports.
// Reset clears the queue, sets the line count to one and the column to zero.
// After an error result the block takes and drops all input until reset.
module char_stream_token_lexer #(
	parameter int POSITION_WIDTH = cstl_pkg::POS_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_stall,
	input  logic [7:0]                char_code,
	input  logic                      end_of_input,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [3:0]                result_kind,
	output logic [2:0]                error_code,
	output logic [7:0]                text_char,
	output logic [POSITION_WIDTH-1:0] line_pos,
	output logic [POSITION_WIDTH-1:0] column_pos,
	output logic                      last_of_run
);

	localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

	// Scanner state.
	cstl_pkg::mode_t              mode_q, mode_d;
	logic                         oct_bad_q, oct_bad_d;
	logic                         frac_q, frac_d;
	logic                         digits_q, digits_d;
	logic [POSITION_WIDTH-1:0]    line_q, col_q, col_inc;

	// Result queue: one entry holds every result of one input beat.
	cstl_pkg::bundle_t            fifo_q [cstl_pkg::FIFO_DEPTH];
	logic [POSITION_WIDTH-1:0]    line_mem_q [cstl_pkg::FIFO_DEPTH];
	logic [POSITION_WIDTH-1:0]    col_mem_q [cstl_pkg::FIFO_DEPTH];
	logic [cstl_pkg::PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [cstl_pkg::FILL_W-1:0]  fill_q;
	logic [cstl_pkg::IDX_W-1:0]   idx_q;

	cstl_pkg::bundle_t            bun;
	cstl_pkg::bundle_t            head;
	logic [7:0]                   c;
	logic                         eof;
	logic                         in_beat, push, out_beat, pop, last_res;
	logic                         num_path, dot_path, is_oct, finish, dot_after, run_idle;

	assign c   = char_code;
	assign eof = end_of_input;

	assign char_stall = (fill_q == cstl_pkg::FILL_W'(cstl_pkg::FIFO_DEPTH));
	assign in_beat    = char_valid && !char_stall;

	// Columns advance on every character beat, before its results are made.
	assign col_inc = (eof || col_q == POS_MAX) ? col_q : col_q + POSITION_WIDTH'(1);

	// Decode of one character against the current scan mode. Emission order
	// matters: a pending token, then a held dot, then the token the new
	// character starts.
	always_comb begin
		mode_d    = mode_q;
		oct_bad_d = oct_bad_q;
		frac_d    = frac_q;
		digits_d  = digits_q;
		bun       = '0;
		num_path  = 1'b0;
		dot_path  = 1'b0;
		is_oct    = 1'b0;
		finish    = 1'b0;
		dot_after = 1'b0;
		run_idle  = 1'b0;

		case (mode_q)
			cstl_pkg::MODE_HALT: begin
			end
			cstl_pkg::MODE_SLASH: begin
				if (!eof && c == cstl_pkg::CH_SLASH) begin
					mode_d = cstl_pkg::MODE_LINE;
				end else if (!eof && c == cstl_pkg::CH_STAR) begin
					mode_d = cstl_pkg::MODE_BLOCK;
				end else begin
					bun = cstl_pkg::add(bun, cstl_pkg::K_DIV, cstl_pkg::E_NONE, 8'd0);
					run_idle = 1'b1;
				end
			end
			cstl_pkg::MODE_LINE: begin
				if (eof) begin
					run_idle = 1'b1;
				end else if (c == cstl_pkg::CH_LF) begin
					mode_d = cstl_pkg::MODE_IDLE;
				end
			end
			cstl_pkg::MODE_BLOCK, cstl_pkg::MODE_STAR: begin
				if (eof) begin
					bun = cstl_pkg::add(bun, cstl_pkg::K_ERR, cstl_pkg::E_EOF_CMT, 8'd0);
					mode_d = cstl_pkg::MODE_HALT;
				end else if (c == cstl_pkg::CH_STAR) begin
					mode_d = cstl_pkg::MODE_STAR;
				end else if (c == cstl_pkg::CH_SLASH && mode_q == cstl_pkg::MODE_STAR) begin
					mode_d = cstl_pkg::MODE_IDLE;
				end else begin
					mode_d = cstl_pkg::MODE_BLOCK;
				end
			end
			cstl_pkg::MODE_ZERO: begin
				if (!eof && c == cstl_pkg::CH_B) begin
					mode_d   = cstl_pkg::MODE_BIN;
					digits_d = 1'b0;
				end else if (!eof && c == cstl_pkg::CH_X) begin
					mode_d   = cstl_pkg::MODE_HEX;
					digits_d = 1'b0;
				end else begin
					// The leading zero was held back; it becomes octal text now.
					bun = cstl_pkg::add(bun, cstl_pkg::K_TEXT, cstl_pkg::E_NONE, cstl_pkg::CH_0);
					mode_d    = cstl_pkg::MODE_OCT;
					frac_d    = 1'b0;
					oct_bad_d = 1'b0;
					num_path  = 1'b1;
					is_oct    = 1'b1;
				end
			end
			cstl_pkg::MODE_DEC: begin
				num_path = 1'b1;
			end
			cstl_pkg::MODE_OCT: begin
				num_path = 1'b1;
				is_oct   = 1'b1;
			end
			cstl_pkg::MODE_DEC_DOT: begin
				dot_path = 1'b1;
			end
			cstl_pkg::MODE_OCT_DOT: begin
				dot_path = 1'b1;
				is_oct   = 1'b1;
			end
			cstl_pkg::MODE_BIN: begin
				if (!eof && (c == cstl_pkg::CH_0 || c == cstl_pkg::CH_1)) begin
					bun = cstl_pkg::add(bun, cstl_pkg::K_TEXT, cstl_pkg::E_NONE, c);
					digits_d = 1'b1;
				end else if (!digits_q || (!eof && cstl_pkg::is_digit(c))) begin
					bun = cstl_pkg::add(bun, cstl_pkg::K_ERR, cstl_pkg::E_BIN, 8'd0);
					mode_d = cstl_pkg::MODE_HALT;
				end else begin
					bun = cstl_pkg::add(bun, cstl_pkg::K_BIN, cstl_pkg::E_NONE, 8'd0);
					run_idle = 1'b1;
				end
			end
			cstl_pkg::MODE_HEX: begin
				if (!eof && cstl_pkg::is_hex(c)) begin
					bun = cstl_pkg::add(bun, cstl_pkg::K_TEXT, cstl_pkg::E_NONE, c);
					digits_d = 1'b1;
				end else if (!digits_q || (!eof && cstl_pkg::is_alpha(c))) begin
					bun = cstl_pkg::add(bun, cstl_pkg::K_ERR, cstl_pkg::E_HEX, 8'd0);
					mode_d = cstl_pkg::MODE_HALT;
				end else begin
					bun = cstl_pkg::add(bun, cstl_pkg::K_HEX, cstl_pkg::E_NONE, 8'd0);
					run_idle = 1'b1;
				end
			end
			default: begin
				run_idle = 1'b1;
			end
		endcase

		// Inside a decimal or octal number.
		if (num_path) begin
			if (!eof && cstl_pkg::is_digit(c)) begin
				bun = cstl_pkg::add(bun, cstl_pkg::K_TEXT, cstl_pkg::E_NONE, c);
				if (is_oct && c > cstl_pkg::CH_7) begin
					oct_bad_d = 1'b1;
				end
			end else if (!eof && c == cstl_pkg::CH_DOT && !frac_d) begin
				mode_d = is_oct ? cstl_pkg::MODE_OCT_DOT : cstl_pkg::MODE_DEC_DOT;
			end else begin
				finish = 1'b1;
			end
		end

		// A dot is held after digits until the next character shows its role.
		if (dot_path) begin
			if (!eof && cstl_pkg::is_digit(c)) begin
				bun = cstl_pkg::add(bun, cstl_pkg::K_TEXT, cstl_pkg::E_NONE, cstl_pkg::CH_DOT);
				bun = cstl_pkg::add(bun, cstl_pkg::K_TEXT, cstl_pkg::E_NONE, c);
				if (is_oct && c > cstl_pkg::CH_7) begin
					oct_bad_d = 1'b1;
				end
				frac_d = 1'b1;
				mode_d = is_oct ? cstl_pkg::MODE_OCT : cstl_pkg::MODE_DEC;
			end else begin
				finish    = 1'b1;
				dot_after = 1'b1;
			end
		end

		if (finish) begin
			if (is_oct && oct_bad_d) begin
				bun = cstl_pkg::add(bun, cstl_pkg::K_ERR, cstl_pkg::E_OCT, 8'd0);
				mode_d = cstl_pkg::MODE_HALT;
			end else begin
				bun = cstl_pkg::add(bun, is_oct ? cstl_pkg::K_OCT : cstl_pkg::K_DEC,
					cstl_pkg::E_NONE, 8'd0);
				if (dot_after) begin
					bun = cstl_pkg::add(bun, cstl_pkg::K_DOT, cstl_pkg::E_NONE, 8'd0);
				end
				run_idle = 1'b1;
			end
		end

		// Scan between tokens.
		if (run_idle) begin
			mode_d = cstl_pkg::MODE_IDLE;
			if (eof) begin
				bun = cstl_pkg::add(bun, cstl_pkg::K_EOF, cstl_pkg::E_NONE, 8'd0);
			end else begin
				case (c) inside
					cstl_pkg::CH_TAB, cstl_pkg::CH_VT, cstl_pkg::CH_SP,
					cstl_pkg::CH_CR, cstl_pkg::CH_LF: begin
					end
					cstl_pkg::CH_PLUS: begin
						bun = cstl_pkg::add(bun, cstl_pkg::K_PLUS, cstl_pkg::E_NONE, 8'd0);
					end
					cstl_pkg::CH_MINUS: begin
						bun = cstl_pkg::add(bun, cstl_pkg::K_MINUS, cstl_pkg::E_NONE, 8'd0);
					end
					cstl_pkg::CH_STAR: begin
						bun = cstl_pkg::add(bun, cstl_pkg::K_MUL, cstl_pkg::E_NONE, 8'd0);
					end
					cstl_pkg::CH_LPAR: begin
						bun = cstl_pkg::add(bun, cstl_pkg::K_LPAREN, cstl_pkg::E_NONE, 8'd0);
					end
					cstl_pkg::CH_RPAR: begin
						bun = cstl_pkg::add(bun, cstl_pkg::K_RPAREN, cstl_pkg::E_NONE, 8'd0);
					end
					cstl_pkg::CH_SEMI: begin
						bun = cstl_pkg::add(bun, cstl_pkg::K_SEMI, cstl_pkg::E_NONE, 8'd0);
					end
					cstl_pkg::CH_DOT: begin
						bun = cstl_pkg::add(bun, cstl_pkg::K_DOT, cstl_pkg::E_NONE, 8'd0);
					end
					cstl_pkg::CH_SLASH: begin
						mode_d = cstl_pkg::MODE_SLASH;
					end
					cstl_pkg::CH_0: begin
						mode_d = cstl_pkg::MODE_ZERO;
					end
					[cstl_pkg::CH_1:cstl_pkg::CH_9]: begin
						bun = cstl_pkg::add(bun, cstl_pkg::K_TEXT, cstl_pkg::E_NONE, c);
						mode_d    = cstl_pkg::MODE_DEC;
						frac_d    = 1'b0;
						oct_bad_d = 1'b0;
					end
					default: begin
						bun = cstl_pkg::add(bun, cstl_pkg::K_ERR, cstl_pkg::E_UNEXP, 8'd0);
						mode_d = cstl_pkg::MODE_HALT;
					end
				endcase
			end
		end
	end

	// Scanner registers. A halted scanner holds everything, counters included.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= cstl_pkg::MODE_IDLE;
			oct_bad_q <= 1'b0;
			frac_q    <= 1'b0;
			digits_q  <= 1'b0;
			line_q    <= POSITION_WIDTH'(1);
			col_q     <= '0;
		end else if (in_beat && mode_q != cstl_pkg::MODE_HALT) begin
			mode_q    <= mode_d;
			oct_bad_q <= oct_bad_d;
			frac_q    <= frac_d;
			digits_q  <= digits_d;
			if (!eof && c == cstl_pkg::CH_LF && mode_d != cstl_pkg::MODE_HALT) begin
				line_q <= (line_q == POS_MAX) ? line_q : line_q + POSITION_WIDTH'(1);
				col_q  <= '0;
			end else begin
				col_q  <= col_inc;
			end
		end
	end

	// Result queue. Beats that cause no result are not queued.
	assign push     = in_beat && (bun.cnt != '0);
	assign head     = fifo_q[rd_ptr_q];
	assign last_res = (cstl_pkg::CNT_W'(idx_q) == head.cnt - cstl_pkg::CNT_W'(1));
	assign out_beat = result_valid && !result_stall;
	assign pop      = out_beat && last_res;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q]     <= bun;
			line_mem_q[wr_ptr_q] <= line_q;
			col_mem_q[wr_ptr_q]  <= col_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			idx_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + cstl_pkg::PTR_W'(1);
			end
			if (out_beat) begin
				if (last_res) begin
					idx_q    <= '0;
					rd_ptr_q <= rd_ptr_q + cstl_pkg::PTR_W'(1);
				end else begin
					idx_q    <= idx_q + cstl_pkg::IDX_W'(1);
				end
			end
			if (push && !pop) begin
				fill_q <= fill_q + cstl_pkg::FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - cstl_pkg::FILL_W'(1);
			end
		end
	end

	assign result_valid = (fill_q != '0);
	assign result_kind  = head.kind[idx_q];
	assign error_code   = head.code[idx_q];
	assign text_char    = head.text[idx_q];
	assign line_pos     = line_mem_q[rd_ptr_q];
	assign column_pos   = col_mem_q[rd_ptr_q];
	assign last_of_run  = last_res;

endmodule

/* rtl/cstl_chk.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cstl_chk #(
	parameter int POSITION_WIDTH = cstl_pkg::POS_WIDTH_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic [3:0]                result_kind,
	input logic [2:0]                error_code,
	input logic [7:0]                text_char,
	input logic [POSITION_WIDTH-1:0] line_pos,
	input logic                      last_of_run
);

	logic out_beat, stalled, is_err, code_set, text_ok;

	assign out_beat = result_valid && !result_stall;
	assign stalled  = result_valid && result_stall;
	assign is_err   = (result_kind == cstl_pkg::K_ERR);
	assign code_set = (error_code != cstl_pkg::E_NONE);
	assign text_ok  = (result_kind == cstl_pkg::K_TEXT) || (text_char == 8'd0);

	// An error halts the scanner, so nothing follows the error beat.
	`CSTL_ASSERT_MSG(a_halt_drains, out_beat && is_err |=> !result_valid, "result after error")

	`CSTL_ASSERT(a_err_ends_run, result_valid && is_err |-> last_of_run && code_set)

	`CSTL_ASSERT(a_fields_clean, result_valid && !is_err |-> !code_set && text_ok)

	`CSTL_ASSERT(a_line_nonzero, result_valid |-> line_pos != '0)

	`CSTL_ASSERT(a_stall_hold, stalled |=> result_valid && $stable(result_kind) && $stable(last_of_run))

endmodule

bind char_stream_token_lexer cstl_chk #(.POSITION_WIDTH(POSITION_WIDTH)) u_cstl_chk (.*);
